/* design/telemetry_frame_sum_framer_assert.svh */
// Assertion helpers shared by the framer RTL.
`ifndef TELEMETRY_FRAME_SUM_FRAMER_ASSERT_SVH
`define TELEMETRY_FRAME_SUM_FRAMER_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define TFSF_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define TFSF_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* design/tfsf_pkg.sv */
`default_nettype none
package tfsf_pkg;

   localparam int MAX_PAYLOAD = 27;
   localparam int LANE_BYTES  = 8;
   localparam int NUM_LANES   = 4;
   localparam int WORD_W      = 64;
   localparam int TAIL_W      = 24;
   localparam int COUNT_W     = 4;   // 0..LANE_BYTES
   localparam int LEN_W       = 5;   // 0..MAX_PAYLOAD
   localparam int IDX_W       = 5;   // frame byte index 0..MAX_PAYLOAD+4
   localparam int LANE_SEL_W  = 2;
   localparam int BYTE_SEL_W  = 3;

   localparam logic [7:0] HEADER_BYTE = 8'hAA;

   // Frame layout: two header bytes, function code, length, payload, checksum.
   localparam logic [IDX_W-1:0] IDX_FUNC    = 5'd2;
   localparam logic [IDX_W-1:0] IDX_LEN     = 5'd3;
   localparam logic [IDX_W-1:0] IDX_PAYLOAD = 5'd4;

   typedef struct packed {
      logic [WORD_W-1:0]  word;
      logic [COUNT_W-1:0] count;   // bytes of this word inside the payload
   } lane_in_type;

endpackage
`default_nettype wire

/* design/tfsf_lane.sv */
`default_nettype none
module tfsf_lane (
   input  wire logic                clock,
   input  wire tfsf_pkg::lane_in_type lane_in,
   output logic [7:0]               lane_sum
);
   import tfsf_pkg::*;

   logic [7:0] sum_in;
   logic [7:0] sum_ff;

   // masked byte sum over one payload word
   always_comb begin
      sum_in = 8'd0;
      for (int i = 0; i < LANE_BYTES; i++) begin
         if (COUNT_W'(i) < lane_in.count) begin
            sum_in = sum_in + lane_in.word[i*8 +: 8];
         end
      end
   end

   always_ff @(posedge clock) begin
      sum_ff <= sum_in;
   end

   assign lane_sum = sum_ff;

endmodule
`default_nettype wire

/* design/tfsf_merge.sv */
`default_nettype none
module tfsf_merge (
   input  wire logic       clock,
   input  wire logic [7:0] lane_sum [tfsf_pkg::NUM_LANES],
   input  wire logic [7:0] function_code,
   input  wire logic [7:0] payload_length,
   output logic [7:0]      checksum
);
   import tfsf_pkg::*;

   logic [7:0] checksum_in;
   logic [7:0] checksum_ff;

   always_comb begin
      checksum_in = HEADER_BYTE + HEADER_BYTE + function_code + payload_length;
      for (int l = 0; l < NUM_LANES; l++) begin
         checksum_in = checksum_in + lane_sum[l];
      end
   end

   always_ff @(posedge clock) begin
      checksum_ff <= checksum_in;
   end

   assign checksum = checksum_ff;

endmodule
`default_nettype wire

/* design/telemetry_frame_sum_framer.sv */
// Telemetry frame builder with 8-bit additive checksum.
// req_ channel: one beat is a frame request (function code, length and up
//   to 27 payload bytes in four words, byte 0 in the low bits of word 0).
//   A request with length above 27 is accepted and dropped: no output.
// rsp_ channel: one beat per frame byte: AA, AA, function code, length,
//   payload bytes, then the checksum with rsp_last_byte high.
// The request is registered first, then the first byte is loaded into the output
//   register. A frame of n payload bytes takes n+5 rsp beats, one per
//   cycle when the receiver does not stall.
// The byte serializer limits the request rate: req_stall is high while a frame
//   is being sent and drops once the checksum sits in the output register,
//   so the next request can be taken while that byte may still wait.
// The checksum comes from four lanes, each summing the valid bytes of one
//   payload word, and a merge stage, both registered; it is ready before
//   the serializer reaches the end of the shortest frame.
// Stall on rsp_ holds the output register and pauses the serializer.
// Reset (synchronous) empties the output register and abandons any frame.
`default_nettype none
`include "telemetry_frame_sum_framer_assert.svh"
module telemetry_frame_sum_framer (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_function_code,
   input  wire logic [7:0]  req_payload_length,
   input  wire logic [63:0] req_payload_word_0,
   input  wire logic [63:0] req_payload_word_1,
   input  wire logic [63:0] req_payload_word_2,
   input  wire logic [23:0] req_payload_word_3,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_frame_byte,
   output logic             rsp_last_byte
);
   import tfsf_pkg::*;

   // request capture
   logic              busy_ff, busy_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [LEN_W-1:0]  len_ff;
   logic [7:0]        func_ff;
   logic [WORD_W-1:0] word_ff [NUM_LANES];

   // output register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [7:0]        rsp_byte_ff, rsp_byte_in;
   logic              rsp_last_ff, rsp_last_in;

   logic              req_accept;
   logic              length_ok;
   logic              out_load;
   logic              frame_end;
   logic [IDX_W-1:0]  end_idx;
   logic [IDX_W-1:0]  pay_idx;
   logic [7:0]        pay_byte;
   logic [7:0]        checksum;
   logic [7:0]        lane_sum [NUM_LANES];
   lane_in_type       lane_in  [NUM_LANES];

   assign req_stall  = busy_ff;
   assign req_accept = req_valid && !busy_ff;
   assign length_ok  = req_payload_length <= 8'(MAX_PAYLOAD);

   always_ff @(posedge clock) begin
      if (req_accept) begin
         len_ff     <= req_payload_length[LEN_W-1:0];
         func_ff    <= req_function_code;
         word_ff[0] <= req_payload_word_0;
         word_ff[1] <= req_payload_word_1;
         word_ff[2] <= req_payload_word_2;
         word_ff[3] <= {{(WORD_W-TAIL_W){1'b0}}, req_payload_word_3};
      end
   end

   // per-lane byte counts from the stored length
   always_comb begin
      for (int l = 0; l < NUM_LANES; l++) begin
         lane_in[l].word = word_ff[l];
         if ({1'b0, len_ff} >= (LEN_W+1)'((l+1)*LANE_BYTES)) begin
            lane_in[l].count = COUNT_W'(LANE_BYTES);
         end else if (len_ff > LEN_W'(l*LANE_BYTES)) begin
            lane_in[l].count = COUNT_W'(len_ff - LEN_W'(l*LANE_BYTES));
         end else begin
            lane_in[l].count = '0;
         end
      end
   end

   for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
      tfsf_lane u_lane (
         .clock    (clock),
         .lane_in  (lane_in[g]),
         .lane_sum (lane_sum[g])
      );
   end

   tfsf_merge u_merge (
      .clock          (clock),
      .lane_sum       (lane_sum),
      .function_code  (func_ff),
      .payload_length ({{(8-LEN_W){1'b0}}, len_ff}),
      .checksum       (checksum)
   );

   // byte serializer
   assign end_idx   = IDX_W'(len_ff) + IDX_PAYLOAD;
   assign frame_end = idx_ff == end_idx;
   assign pay_idx   = idx_ff - IDX_PAYLOAD;
   assign pay_byte  = word_ff[pay_idx[IDX_W-1 -: LANE_SEL_W]]
                             [pay_idx[BYTE_SEL_W-1:0]*8 +: 8];
   assign out_load  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      priority if (idx_ff < IDX_FUNC) begin
         rsp_byte_in = HEADER_BYTE;
      end else if (idx_ff == IDX_FUNC) begin
         rsp_byte_in = func_ff;
      end else if (idx_ff == IDX_LEN) begin
         rsp_byte_in = {{(8-LEN_W){1'b0}}, len_ff};
      end else if (frame_end) begin
         rsp_byte_in = checksum;
      end else begin
         rsp_byte_in = pay_byte;
      end
   end

   always_comb begin
      busy_in      = busy_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_last_in  = rsp_last_ff;
      if (out_load) begin
         rsp_valid_in = busy_ff;
         rsp_last_in  = frame_end;
         if (busy_ff) begin
            idx_in = idx_ff + IDX_W'(1);
            if (frame_end) begin
               busy_in = 1'b0;
            end
         end
      end
      if (req_accept) begin
         busy_in = length_ok;
         idx_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load && busy_ff) begin
         rsp_byte_ff <= rsp_byte_in;
         rsp_last_ff <= rsp_last_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_frame_byte = rsp_byte_ff;
   assign rsp_last_byte  = rsp_last_ff;

   `TFSF_ASSERT_NOW(a_idx_in_frame, clock, reset, busy_ff, idx_ff <= end_idx, "index past frame end")
   `TFSF_ASSERT_NEXT(a_drop_long, clock, reset, req_accept && !length_ok, !busy_ff, "long request not dropped")
   `TFSF_ASSERT_NEXT(a_start_frame, clock, reset, req_accept && length_ok, busy_ff && idx_ff == '0, "frame did not start")
   `TFSF_ASSERT_NEXT(a_end_frame, clock, reset, busy_ff && out_load && frame_end, !busy_ff && rsp_valid_ff && rsp_last_ff, "frame did not close")

endmodule
`default_nettype wire
